// ===== rtl/bab_pkg.sv =====
// Shared types, constants and command codes of the bitmap block allocator.
package bab_pkg;

    // Sizing of the device and the metadata areas.
    localparam int MAX_BLOCKS  = 4096;
    localparam int BLOCK_BYTES = 1024;
    localparam int INODE_BYTES = 128;

    // The occupancy map is held as rows of WORD_BITS blocks each.
    localparam int WORD_BITS = 32;
    localparam int MAP_ROWS  = MAX_BLOCKS / WORD_BITS;
    localparam int ROW_AW    = $clog2(MAP_ROWS);
    localparam int ROW_CW    = ROW_AW + 1;
    localparam int BIT_AW    = $clog2(WORD_BITS);
    localparam int BB_SH     = $clog2(BLOCK_BYTES);
    localparam int IB_SH     = $clog2(INODE_BYTES);

    // Field widths.
    localparam int CMD_W      = 3;
    localparam int IDX_W      = 12;
    localparam int CNT_W      = 13;
    localparam int INODES_W   = 14;
    localparam int STATUS_W   = 2;
    localparam int META_W     = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INIT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RESERVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_INODES = 1'd1;
    localparam logic [CNT_W-1:0]     TOTAL_BLOCKS_RST = 13'd4096;
    localparam logic [INODES_W-1:0]  TOTAL_INODES_RST = 14'd1024;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] block_index;
        logic             bit_value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    result_block;
        logic                bit_read;
        logic [CNT_W-1:0]    free_count;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              latch_item;
        logic              init_start;
        logic              fill_we;
        logic              init_done;
        logic              scan_rd;
        logic              scan_commit;
        logic              rmw_rd;
        logic              rmw_commit;
        logic              set_nospace;
        logic              set_range;
        logic              load_out;
        logic [ROW_AW-1:0] row;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic              free_zero;
        logic              oob;
        logic              found;
        logic [ROW_CW-1:0] nrows;
        logic [ROW_CW-1:0] nwords;
    } t_dp_stat;

endpackage

// ===== rtl/bab_if.sv =====
// Handshake channel interfaces for items, results and configuration writes.
interface bab_in_if import bab_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bab_out_if import bab_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bab_cfg_if import bab_pkg::*;;
    logic      valid;
    logic      ready;
    t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bab_dp.sv =====
// Datapath: occupancy map memory, free count, configuration and result registers.
module bab_dp import bab_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_item,
    input  logic      i_cfg_we,
    input  t_cfg_item i_cfg,
    output t_dp_stat  o_stat,
    output t_out_item o_out
);

    logic [CNT_W-1:0]    r_total_blocks;
    logic [INODES_W-1:0] r_total_inodes;
    logic [CNT_W-1:0]    r_free;
    t_in_item            r_item;
    logic [STATUS_W-1:0] r_status;
    logic [IDX_W-1:0]    r_res;
    logic                r_bit;
    logic [META_W-1:0]   r_meta;
    t_out_item           r_out;

    logic [WORD_BITS-1:0] r_mem [MAP_ROWS];
    logic [WORD_BITS-1:0] r_rdq;
    logic                 r_rd_vld;
    logic [ROW_AW-1:0]    r_rd_row;
    logic [MAP_ROWS-1:0]  r_row_vld;

    logic [CNT_W-1:0]     eff_total;
    logic [META_W-1:0]    map_blk;
    logic [META_W-1:0]    inode_blk;
    logic [META_W-1:0]    meta_next;
    logic [CNT_W-1:0]     meta_lim;
    logic [CNT_W-1:0]     free_init;
    logic [WORD_BITS-1:0] fill_mask;
    logic [WORD_BITS-1:0] range_mask;
    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] cand;
    logic [BIT_AW-1:0]    hit;
    logic [BIT_AW-1:0]    ibit;
    logic [ROW_AW-1:0]    irow;
    logic [WORD_BITS-1:0] item_mask;
    logic                 we;
    logic [ROW_AW-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 re;
    logic [ROW_AW-1:0]    raddr;

    assign eff_total = (r_total_blocks < CNT_W'(MAX_BLOCKS)) ? r_total_blocks
                                                              : CNT_W'(MAX_BLOCKS);

    // Metadata size: superblock, map blocks and inode blocks, each rounded up.
    assign map_blk   = (META_W'(r_total_blocks >> 3) + META_W'(BLOCK_BYTES - 1)) >> BB_SH;
    assign inode_blk = ((META_W'(r_total_inodes) << IB_SH) + META_W'(BLOCK_BYTES - 1))
                       >> BB_SH;
    assign meta_next = META_W'(1) + map_blk + inode_blk;

    assign meta_lim  = (META_W'(eff_total) < r_meta) ? eff_total : CNT_W'(r_meta);
    assign free_init = (META_W'(eff_total) > r_meta) ? eff_total - CNT_W'(r_meta)
                                                     : '0;

    // Row i of the metadata fill: all ones below the last partial row.
    always_comb begin
        if (CNT_W'(i_cmd.row) < (meta_lim >> BIT_AW)) begin
            fill_mask = '1;
        end else begin
            fill_mask = (WORD_BITS'(1) << meta_lim[BIT_AW-1:0]) - WORD_BITS'(1);
        end
    end

    // Bits of the row just read that lie below the effective total.
    always_comb begin
        if (CNT_W'(r_rd_row) < (eff_total >> BIT_AW)) begin
            range_mask = '1;
        end else begin
            range_mask = (WORD_BITS'(1) << eff_total[BIT_AW-1:0]) - WORD_BITS'(1);
        end
    end

    assign rdata = r_rd_vld ? r_rdq : '0;
    assign cand  = ~rdata & range_mask;

    // Lowest free bit of the row.
    always_comb begin
        hit = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (cand[j]) begin
                hit = BIT_AW'(j);
            end
        end
    end

    assign ibit      = r_item.block_index[BIT_AW-1:0];
    assign irow      = r_item.block_index[IDX_W-1:BIT_AW];
    assign item_mask = WORD_BITS'(1) << ibit;

    // Single write port shared by the init fill, reserve and bit updates.
    always_comb begin
        we    = i_cmd.fill_we || i_cmd.scan_commit ||
                (i_cmd.rmw_commit &&
                 (r_item.cmd == CMD_RELEASE || r_item.cmd == CMD_WRITE));
        waddr = irow;
        wdata = rdata & ~item_mask;
        if (i_cmd.fill_we) begin
            waddr = i_cmd.row;
            wdata = fill_mask;
        end else if (i_cmd.scan_commit) begin
            waddr = r_rd_row;
            wdata = rdata | (WORD_BITS'(1) << hit);
        end else if (r_item.cmd == CMD_WRITE && r_item.bit_value) begin
            wdata = rdata | item_mask;
        end
    end

    assign re    = i_cmd.scan_rd || i_cmd.rmw_rd;
    assign raddr = i_cmd.scan_rd ? i_cmd.row : irow;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdq    <= r_mem[raddr];
            r_rd_row <= raddr;
        end
    end

    // Row valid flags: a row not written since reset or init reads as free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_cmd.init_start) begin
                r_row_vld <= '0;
            end else if (we) begin
                r_row_vld[waddr] <= 1'b1;
            end
            if (re) begin
                r_rd_vld <= r_row_vld[raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_blocks <= TOTAL_BLOCKS_RST;
            r_total_inodes <= TOTAL_INODES_RST;
            r_free         <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg.index)
                    REG_TOTAL_BLOCKS: r_total_blocks <= i_cfg.value[CNT_W-1:0];
                    REG_TOTAL_INODES: r_total_inodes <= i_cfg.value[INODES_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.init_done) begin
                r_free <= free_init;
            end else if (i_cmd.scan_commit) begin
                r_free <= r_free - CNT_W'(1);
            end else if (i_cmd.rmw_commit && r_item.cmd == CMD_RELEASE &&
                         r_free < eff_total) begin
                r_free <= r_free + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_item) begin
            r_item   <= i_item;
            r_status <= ST_OK;
            r_res    <= i_item.block_index;
            r_bit    <= 1'b0;
        end
        if (i_cmd.init_start) begin
            r_meta <= meta_next;
        end
        if (i_cmd.set_nospace) begin
            r_status <= ST_NOSPACE;
        end
        if (i_cmd.set_range) begin
            r_status <= ST_RANGE;
        end
        if (i_cmd.scan_commit) begin
            r_res <= {r_rd_row, hit};
        end
        if (i_cmd.rmw_commit && r_item.cmd == CMD_READ) begin
            r_bit <= rdata[ibit];
        end
        if (i_cmd.load_out) begin
            r_out.status       <= r_status;
            r_out.result_block <= r_res;
            r_out.bit_read     <= r_bit;
            r_out.free_count   <= r_free;
        end
    end

    assign o_stat.free_zero = (r_free == '0);
    assign o_stat.oob       = ({1'b0, r_item.block_index} >= eff_total);
    assign o_stat.found     = |cand;
    assign o_stat.nrows     = ROW_CW'((meta_lim + CNT_W'(WORD_BITS - 1)) >> BIT_AW);
    assign o_stat.nwords    = ROW_CW'((eff_total + CNT_W'(WORD_BITS - 1)) >> BIT_AW);
    assign o_out            = r_out;

endmodule

// ===== rtl/bab_ctrl.sv =====
// Controller: sequences init fill, reserve scan and single-bit reads and updates.
module bab_ctrl import bab_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [CMD_W-1:0] i_in_cmd,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  t_dp_stat         i_stat,
    output t_dp_cmd          o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INIT_FILL,
        S_SCAN,
        S_RMW,
        S_FINISH
    } t_state;

    t_state            r_state, n_state;
    logic [CMD_W-1:0]  r_cmd;
    logic [ROW_CW-1:0] r_row, n_row;
    logic              r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    logic              accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd       = '0;
        o_cmd.row   = r_row[ROW_AW-1:0];
        n_state     = r_state;
        n_row       = r_row;
        n_pend      = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.latch_item = 1'b1;
                    n_state          = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_row = '0;
                unique case (r_cmd) inside
                    CMD_INIT: begin
                        o_cmd.init_start = 1'b1;
                        n_state          = S_INIT_FILL;
                    end
                    CMD_RESERVE: begin
                        if (i_stat.free_zero) begin
                            o_cmd.set_nospace = 1'b1;
                            n_state           = S_FINISH;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    CMD_RELEASE, CMD_READ, CMD_WRITE: begin
                        if (i_stat.oob) begin
                            o_cmd.set_range = 1'b1;
                            n_state         = S_FINISH;
                        end else begin
                            o_cmd.rmw_rd = 1'b1;
                            n_state      = S_RMW;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_INIT_FILL: begin
                if (r_row < i_stat.nrows) begin
                    o_cmd.fill_we = 1'b1;
                    n_row         = r_row + ROW_CW'(1);
                end else begin
                    o_cmd.init_done = 1'b1;
                    n_state         = S_FINISH;
                end
            end
            S_SCAN: begin
                if (r_pend && i_stat.found) begin
                    o_cmd.scan_commit = 1'b1;
                    n_state           = S_FINISH;
                end else if (r_row < i_stat.nwords) begin
                    o_cmd.scan_rd = 1'b1;
                    n_row         = r_row + ROW_CW'(1);
                    n_pend        = 1'b1;
                end else begin
                    o_cmd.set_nospace = 1'b1;
                    n_state           = S_FINISH;
                end
            end
            S_RMW: begin
                o_cmd.rmw_commit = 1'b1;
                n_state          = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd       <= CMD_INIT;
            r_row       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_cmd <= i_in_cmd;
            end
        end
    end

endmodule

// ===== rtl/bitmap_block_allocator.sv =====
// Top level of the first-fit bitmap block allocator.
//
// Items enter on i_in (cmd, block_index, bit_value) and each one gives exactly one
// result on o_out (status, result_block, bit_read, free_count). Registers
// total_blocks (index 0) and total_inodes (index 1) are written on i_cfg, which is
// always ready; write them only while no item is in flight.
// The map is held as 128 rows of 32 blocks in one memory with a single write
// port and a registered read. The block works on one item at a time. Unknown
// codes, an index out of range and reserve with a zero free count go straight
// to the result; release, read bit and write bit do one read-modify-write of a
// row; init writes each map row covered by metadata (up to 128); reserve scans
// the rows one per cycle until it finds a free bit or passes the last row of
// the device.
// Results sit in an output register: the next item is accepted while a result
// waits, and if the receiver still stalls when that item is done, the block
// holds its result internally until the output register drains.
// Reset clears all row valid flags at once so the whole map reads as free, sets
// the free count to zero and the registers to 4096 blocks and 1024 inodes; no
// clearing pass is needed and items are accepted on the first cycle after reset.
module bitmap_block_allocator import bab_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bab_in_if.sink      i_in,
    bab_out_if.source   o_out,
    bab_cfg_if.sink     i_cfg
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Configuration writes are taken in any cycle.
    assign i_cfg.ready = 1'b1;

    bab_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_in_cmd    (i_in.data.cmd),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    bab_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_item   (i_in.data),
        .i_cfg_we (i_cfg.valid),
        .i_cfg    (i_cfg.data),
        .o_stat   (dp_stat),
        .o_out    (o_out.data)
    );

`ifndef SYNTHESIS
    // Only one item is worked on at a time: the input closes after each accept.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input accepted again right after an accept");

    // A range error never reports a map bit.
    a_range_no_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.status == ST_RANGE |-> !o_out.data.bit_read)
        else $error("range error result carries a map bit");

    // The free count never exceeds the device size.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.data.free_count <= CNT_W'(MAX_BLOCKS))
        else $error("free count above the maximum block count");
`endif

endmodule

// ===== tb/tb_bitmap_block_allocator.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the first-fit bitmap block allocator.
module tb_bitmap_block_allocator;
    import bab_pkg::*;

    // Command codes 5 to 7 have no meaning and must be ignored by the block.
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_FIRST = CMD_WRITE + 3'd1;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LAST  = '1;

    // Register settings walked through after the directed part. The first
    // entries hit the extremes: a single block, no blocks at all, a total above
    // the map size (the 14-bit write is masked to 13 bits), and inode areas
    // large enough to push the metadata past the end of the device.
    localparam int FIXED_SETTINGS   = 11;
    localparam int RANDOM_SETTINGS  = 5;
    localparam int ITEMS_PER_PHASE  = 83;

    logic i_clk;
    logic i_rst_n;

    bab_in_if  in_ch ();
    bab_out_if out_ch ();
    bab_cfg_if cfg_ch ();

    bitmap_block_allocator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Items waiting to be driven and results waiting to be seen.
    t_in_item  pending_items[$];
    t_out_item expected_results[$];

    // Allocator state as the testbench predicts it.
    bit [MAX_BLOCKS-1:0] model_map;
    int unsigned         model_free;
    int unsigned         model_total_blocks;
    int unsigned         model_total_inodes;

    // Handshake bookkeeping. Each counter has a single writer.
    int unsigned items_offered;
    int unsigned items_taken;
    int unsigned cfg_writes;
    int unsigned send_gap;
    int unsigned ready_hold;
    bit          quiet_sender;
    bit          quiet_receiver;

    // Run statistics.
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned reserves_granted;
    int unsigned nospace_seen;
    int unsigned range_seen;
    int unsigned inits_seen;
    int unsigned settings_used;

    t_out_item seen_result;
    t_out_item wanted_result;

    // Clock: 10 ns period.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Blocks taken by the superblock, the map itself and the inode area.
    // The map area is sized from the raw register value, not the clamped total.
    function automatic int unsigned metadata_blocks(input int unsigned blocks,
                                                    input int unsigned inodes);
        return 1 + (blocks / 8 + BLOCK_BYTES - 1) / BLOCK_BYTES
                 + (inodes * INODE_BYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;
    endfunction

    function automatic int unsigned usable_blocks(input int unsigned blocks);
        return (blocks < MAX_BLOCKS) ? blocks : MAX_BLOCKS;
    endfunction

    // Works out the result of one command and advances the predicted state.
    function automatic t_out_item predict_allocator(input t_in_item it);
        t_out_item   res;
        int unsigned total;
        int unsigned meta;
        int unsigned n;
        total            = usable_blocks(model_total_blocks);
        res.status       = ST_OK;
        res.result_block = it.block_index;
        res.bit_read     = 1'b0;
        case (it.cmd)
            CMD_INIT: begin
                // Metadata blocks beyond the usable total are simply not marked.
                meta      = metadata_blocks(model_total_blocks, model_total_inodes);
                model_map = '0;
                for (n = 0; n < meta && n < total; n++) begin
                    model_map[n] = 1'b1;
                end
                model_free = (total > meta) ? total - meta : 0;
                inits_seen++;
            end
            CMD_RESERVE: begin
                // A zero free count wins even when the map still has a hole.
                n = total;
                if (model_free != 0) begin
                    n = 0;
                    while (n < total && model_map[n]) n++;
                end
                if (n < total) begin
                    model_map[n]     = 1'b1;
                    model_free       = model_free - 1;
                    res.result_block = n[IDX_W-1:0];
                    reserves_granted++;
                end else begin
                    res.status = ST_NOSPACE;
                    nospace_seen++;
                end
            end
            CMD_RELEASE, CMD_READ, CMD_WRITE: begin
                if (it.block_index >= total) begin
                    res.status = ST_RANGE;
                    range_seen++;
                end else begin
                    case (it.cmd)
                        CMD_RELEASE: begin
                            // Freeing a free block still bumps the count, up to the total.
                            model_map[it.block_index] = 1'b0;
                            if (model_free < total) model_free++;
                        end
                        CMD_READ: begin
                            res.bit_read = model_map[it.block_index];
                        end
                        default: begin
                            // Writing a bit never touches the free count.
                            model_map[it.block_index] = it.bit_value;
                        end
                    endcase
                end
            end
            default: begin
                // Unknown codes answer OK with the index echoed.
            end
        endcase
        res.free_count = model_free[CNT_W-1:0];
        return res;
    endfunction

    // Idle spans: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random command aimed at the current setting. Most indexes land inside the
    // device, about half of those close to the metadata and the first reserved
    // blocks where releases and reads matter; the rest span all twelve bits or
    // sit right at the upper edge of the device.
    function automatic t_in_item random_alloc_item(input int unsigned total,
                                                   input int unsigned window);
        t_in_item    it;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3)        it.cmd = CMD_INIT;
        else if (r < 40)  it.cmd = CMD_RESERVE;
        else if (r < 62)  it.cmd = CMD_RELEASE;
        else if (r < 78)  it.cmd = CMD_READ;
        else if (r < 96)  it.cmd = CMD_WRITE;
        else              it.cmd = CMD_W'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST));
        r = $urandom_range(0, 99);
        if (r < 70 && total != 0) begin
            if (r < 35) it.block_index = IDX_W'($urandom_range(0, window));
            else        it.block_index = IDX_W'($urandom_range(0, total - 1));
        end else if (r < 88) begin
            it.block_index = IDX_W'($urandom);
        end else begin
            it.block_index = IDX_W'((total + $urandom_range(0, 2) > MAX_BLOCKS - 1) ?
                                    MAX_BLOCKS - 1 : total + $urandom_range(0, 2));
        end
        it.bit_value = 1'($urandom);
        return it;
    endfunction

    task automatic queue_item(input logic [CMD_W-1:0] cmd, input int unsigned idx,
                              input bit val);
        t_in_item it;
        it.cmd         = cmd;
        it.block_index = IDX_W'(idx);
        it.bit_value   = val;
        pending_items.push_back(it);
    endtask

    task automatic report_failure(input string what);
        mismatches++;
        if (mismatches <= 10) $display("ERROR at %0t ns: %s", $time, what);
    endtask

    // Waits until every queued item has been taken and answered. The sender is
    // starved meanwhile, so this also serves as the full drain between phases.
    task automatic wait_for_drain();
        while (pending_items.size() != 0 || items_taken != items_offered ||
               expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // One register write on the configuration channel; only used while idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input int unsigned val);
        int unsigned target;
        @(negedge i_clk);
        cfg_ch.data.index <= idx;
        cfg_ch.data.value <= CFG_DATA_W'(val);
        cfg_ch.valid      <= 1'b1;
        target = cfg_writes + 1;
        while (cfg_writes != target) @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Sender: presents queued items at the falling edge and holds each one
    // until the monitor has seen it accepted, then idles for a random gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && items_taken != items_offered) begin
            // The current item is still waiting for ready.
        end else if (send_gap != 0) begin
            send_gap--;
            in_ch.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
            in_ch.data  <= pending_items.pop_front();
            in_ch.valid <= 1'b1;
            items_offered++;
            send_gap = quiet_sender ? 0 : pick_gap();
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Receiver: ready with random stalls of varying length.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (ready_hold != 0) begin
            ready_hold--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if (!quiet_receiver && $urandom_range(0, 99) < 25) ready_hold = pick_gap() + 1;
        end
    end

    // Monitor: everything is sampled at the rising edge. Results are checked
    // before the item accepted on the same edge is predicted, so a result that
    // arrives with nothing outstanding is caught.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                seen_result = out_ch.data;
                results_checked++;
                if (expected_results.size() == 0) begin
                    report_failure($sformatf("result with nothing expected: status %0d block %0d",
                                             seen_result.status, seen_result.result_block));
                end else begin
                    wanted_result = expected_results.pop_front();
                    if (seen_result.status !== wanted_result.status ||
                        seen_result.result_block !== wanted_result.result_block ||
                        seen_result.bit_read !== wanted_result.bit_read ||
                        seen_result.free_count !== wanted_result.free_count) begin
                        report_failure($sformatf(
                            "result %0d: want st %0d blk %0d bit %0d free %0d, got st %0d blk %0d bit %0d free %0d",
                            results_checked, wanted_result.status, wanted_result.result_block,
                            wanted_result.bit_read, wanted_result.free_count,
                            seen_result.status, seen_result.result_block,
                            seen_result.bit_read, seen_result.free_count));
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                expected_results.push_back(predict_allocator(in_ch.data));
                items_taken++;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.data.index == REG_TOTAL_BLOCKS)
                    model_total_blocks = cfg_ch.data.value[CNT_W-1:0];
                else
                    model_total_inodes = cfg_ch.data.value[INODES_W-1:0];
                cfg_writes++;
            end
        end
    end

    // Stimulus.
    initial begin
        int unsigned blk_setting[FIXED_SETTINGS];
        int unsigned inode_setting[FIXED_SETTINGS];
        int unsigned blocks;
        int unsigned inodes;
        int unsigned total;
        int unsigned window;
        int          p;
        int          k;

        blk_setting   = '{4096, 1, 0, 8191, 16383, 9, 37, 64, 200, 4095, 1};
        inode_setting = '{1024, 0, 0, 16383, 8192, 8, 0, 0, 100, 8192, 8192};

        // Every input is known from time zero; reset is asserted first and then released.
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.data         = '0;
        out_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        quiet_sender       = 1'b0;
        quiet_receiver     = 1'b0;
        model_map          = '0;
        model_free         = 0;
        model_total_blocks = TOTAL_BLOCKS_RST;
        model_total_inodes = TOTAL_INODES_RST;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset settings (4096 blocks, 1024 inodes, 130 metadata
        // blocks). Before any init the count is zero, so reserve has no space
        // although the map is empty, and a release lifts the count anyway.
        queue_item(CMD_READ, 0, 1'b0);
        queue_item(CMD_RESERVE, MAX_BLOCKS - 1, 1'b1);
        queue_item(CMD_RELEASE, 5, 1'b0);
        queue_item(CMD_INIT, 0, 1'b0);
        queue_item(CMD_RESERVE, 0, 1'b0);
        queue_item(CMD_RESERVE, 0, 1'b0);
        queue_item(CMD_RELEASE, 130, 1'b0);
        // Releasing a block that is already free.
        queue_item(CMD_RELEASE, 130, 1'b0);
        queue_item(CMD_READ, 131, 1'b0);
        queue_item(CMD_WRITE, MAX_BLOCKS - 1, 1'b1);
        queue_item(CMD_READ, MAX_BLOCKS - 1, 1'b0);
        queue_item(CMD_WRITE, MAX_BLOCKS - 1, 1'b0);
        queue_item(CMD_UNKNOWN_FIRST, 2730, 1'b1);
        queue_item(CMD_UNKNOWN_FIRST + 3'd1, 1365, 1'b0);
        queue_item(CMD_UNKNOWN_LAST, MAX_BLOCKS - 1, 1'b1);
        // Clearing a metadata bit by hand makes it the next one handed out.
        queue_item(CMD_WRITE, 0, 1'b0);
        queue_item(CMD_RESERVE, 0, 1'b0);
        wait_for_drain();

        // A 20-block device without inodes, changed after init: the old map
        // stays and the range check follows the new total.
        write_register(REG_TOTAL_BLOCKS, 20);
        write_register(REG_TOTAL_INODES, 0);
        settings_used++;
        queue_item(CMD_RELEASE, 20, 1'b0);
        queue_item(CMD_READ, MAX_BLOCKS - 1, 1'b0);
        queue_item(CMD_WRITE, 19, 1'b1);
        queue_item(CMD_INIT, 0, 1'b0);
        queue_item(CMD_RESERVE, 0, 1'b0);
        wait_for_drain();

        // A device with no blocks: everything is out of range and nothing fits.
        write_register(REG_TOTAL_BLOCKS, 0);
        settings_used++;
        queue_item(CMD_INIT, 0, 1'b0);
        queue_item(CMD_RESERVE, 0, 1'b0);
        queue_item(CMD_READ, 0, 1'b0);

        // Random phases. Each one starts from an idle block, writes both
        // registers and then mostly begins with an init; some phases skip the
        // init so the old map is used under the new setting.
        for (p = 0; p < FIXED_SETTINGS + RANDOM_SETTINGS; p++) begin
            wait_for_drain();
            if (p < FIXED_SETTINGS) begin
                blocks = blk_setting[p];
                inodes = inode_setting[p];
            end else begin
                blocks = $urandom_range(1, 320);
                inodes = $urandom_range(0, 64);
            end
            write_register(REG_TOTAL_BLOCKS, blocks);
            write_register(REG_TOTAL_INODES, inodes);
            settings_used++;
            blocks = blocks & ((1 << CNT_W) - 1);
            total  = usable_blocks(blocks);
            window = metadata_blocks(blocks, inodes) + 64;
            if (total != 0 && window > total - 1) window = total - 1;
            quiet_sender   = ($urandom_range(0, 3) == 0);
            quiet_receiver = ($urandom_range(0, 3) == 0);
            if (p == 0 || $urandom_range(0, 9) < 7) queue_item(CMD_INIT, 0, 1'b0);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                pending_items.push_back(random_alloc_item(total, window));
            end
        end

        wait_for_drain();
        repeat (10) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            report_failure($sformatf("%0d results never arrived", expected_results.size()));
        end
        $display("Covered %0d items under %0d register settings with %0d inits.",
                 items_taken, settings_used, inits_seen);
        $display("Answers: %0d blocks reserved, %0d without space, %0d out of range.",
                 reserves_granted, nospace_seen, range_seen);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== bitmap_block_allocator.f =====
rtl/bab_pkg.sv
rtl/bab_if.sv
rtl/bab_dp.sv
rtl/bab_ctrl.sv
rtl/bitmap_block_allocator.sv
tb/tb_bitmap_block_allocator.sv
